### hdl/llc_pkg.sv
// ----------------------------------------------------------------------------
// llc_pkg: shared types and constants of the light level classifier
// Item and result payloads, command and class codes, register indexes and
// reset values.
// ----------------------------------------------------------------------------
package llc_pkg;

  localparam int SAMPLE_BITS       = 10;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int ALPHA_BITS        = 9;
  localparam int ALPHA_SHIFT       = 8;
  localparam int CFG_BITS          = 10;
  localparam int CFG_IDX_BITS      = 2;

  localparam logic [ALPHA_BITS-1:0]  ALPHA_ONE       = ALPHA_BITS'(256);
  localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET     = ALPHA_BITS'(64);
  localparam logic [SAMPLE_BITS-1:0] DARK_RESET      = SAMPLE_BITS'(650);
  localparam logic [SAMPLE_BITS-1:0] BRIGHT_RESET    = SAMPLE_BITS'(350);
  localparam logic [SAMPLE_BITS-1:0] HYST_RESET      = SAMPLE_BITS'(20);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX      = {SAMPLE_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_START      = 2'd0,
    CMD_MEASURE    = 2'd1,
    CMD_CAL_SAMPLE = 2'd2,
    CMD_CAL_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CLASS_COMFORT = 2'd0,
    CLASS_BRIGHT  = 2'd1,
    CLASS_DARK    = 2'd2
  } class_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DARK   = 2'd0,
    REG_BRIGHT = 2'd1,
    REG_HYST   = 2'd2,
    REG_ALPHA  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             light_class;
    logic [SAMPLE_BITS-1:0] smoothed_level;
  } out_item_t;

  // Calibration controls from the item stage.
  typedef struct packed {
    logic take_sample;
    logic finish;
  } cal_ctl_t;

  // Thresholds derived from the calibration span.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] dark;
    logic [SAMPLE_BITS-1:0] bright;
    logic [SAMPLE_BITS-1:0] hyst;
  } thr_t;

endpackage

### hdl/light_level_classifier_top.sv
// ----------------------------------------------------------------------------
// light_level_classifier_top: smoothed light level classifier
// Filters light samples with an exponential moving average and reports the
// level as comfort, too bright or too dark; calibration sets thresholds.
//
//   channel | direction | handshake           | payload
//   in_     | in        | in_valid / in_stall  | in_item_t  (command, sample)
//   out_    | out       | out_valid / out_stall| out_item_t (light_class, level)
//   cfg_    | in        | cfg_we               | cfg_index, cfg_wdata
//
// One request per clock sustained while out_stall is low; a taken request is
// held in the input register, then loads the result register and raises out_valid.
// The input register and the result register each hold one request, and the
// state update runs in the single stage between them.
// A stall on out_ holds the result register and backs up into in_stall.
// Reset (rst_n low, synchronous) restores register defaults and empties both
// stages.
// ----------------------------------------------------------------------------
module light_level_classifier_top #(
  parameter int FRACTION_BITS = llc_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  llc_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output llc_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [llc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [llc_pkg::CFG_BITS-1:0]     cfg_wdata
);
  import llc_pkg::*;

  localparam int SW = SAMPLE_BITS + FRACTION_BITS;

  logic                   s1_valid_r, s1_valid_nxt;
  in_item_t               s1_data_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic [SW-1:0]          smooth_r, smooth_nxt;
  class_t                 class_r, class_nxt;
  logic [ALPHA_BITS-1:0]  alpha_r, alpha_nxt;
  logic [SAMPLE_BITS-1:0] dark_r, dark_nxt;
  logic [SAMPLE_BITS-1:0] bright_r, bright_nxt;
  logic [SAMPLE_BITS-1:0] hyst_r, hyst_nxt;

  logic                   s1_adv, s1_fire, in_fire;
  cmd_t                   cmd;
  logic [SW-1:0]          ema_level;
  logic [SW-1:0]          load_level;
  logic [SAMPLE_BITS-1:0] meas_level;
  logic signed [SAMPLE_BITS+1:0] lvl_s, bright_lo_s, dark_hi_s;
  class_t                 meas_class;
  cal_ctl_t               cal_ctl;
  thr_t                   cal_thr;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;
  assign cmd      = cmd_t'(s1_data_r.command);

  llc_ema #(.FRACTION_BITS(FRACTION_BITS)) u_ema (
    .old_level (smooth_r),
    .sample    (s1_data_r.sample),
    .alpha     (alpha_r),
    .new_level (ema_level)
  );

  assign cal_ctl.take_sample = s1_fire && (cmd == CMD_CAL_SAMPLE);
  assign cal_ctl.finish      = s1_fire && (cmd == CMD_CAL_FINISH);

  llc_calib u_calib (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cal_ctl),
    .sample (s1_data_r.sample),
    .thr    (cal_thr)
  );

  assign load_level = {s1_data_r.sample, {FRACTION_BITS{1'b0}}};
  assign meas_level = ema_level[SW-1:FRACTION_BITS];

  // Signed compares: bright minus hysteresis may go below zero.
  assign lvl_s       = $signed({2'b00, meas_level});
  assign bright_lo_s = $signed({2'b00, bright_r}) - $signed({2'b00, hyst_r});
  assign dark_hi_s   = $signed({2'b00, dark_r}) + $signed({2'b00, hyst_r});

  always_comb begin
    if (lvl_s <= bright_lo_s)     meas_class = CLASS_BRIGHT;
    else if (lvl_s >= dark_hi_s)  meas_class = CLASS_DARK;
    else                          meas_class = CLASS_COMFORT;
  end

  always_comb begin
    smooth_nxt = smooth_r;
    class_nxt  = class_r;
    alpha_nxt  = alpha_r;
    dark_nxt   = dark_r;
    bright_nxt = bright_r;
    hyst_nxt   = hyst_r;
    if (s1_fire) begin
      case (cmd)
        CMD_START: begin
          smooth_nxt = load_level;
        end
        CMD_MEASURE: begin
          smooth_nxt = ema_level;
          class_nxt  = meas_class;
        end
        CMD_CAL_SAMPLE: begin
        end
        CMD_CAL_FINISH: begin
          smooth_nxt = load_level;
          class_nxt  = CLASS_COMFORT;
          dark_nxt   = cal_thr.dark;
          bright_nxt = cal_thr.bright;
          hyst_nxt   = cal_thr.hyst;
        end
        default: begin
        end
      endcase
    end
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DARK:   dark_nxt   = cfg_wdata[SAMPLE_BITS-1:0];
        REG_BRIGHT: bright_nxt = cfg_wdata[SAMPLE_BITS-1:0];
        REG_HYST:   hyst_nxt   = cfg_wdata[SAMPLE_BITS-1:0];
        REG_ALPHA:  alpha_nxt  = cfg_wdata[ALPHA_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_data_nxt.light_class    = class_nxt;
    out_data_nxt.smoothed_level = smooth_nxt[SW-1:FRACTION_BITS];
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_fire)                   out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      smooth_r    <= '0;
      class_r     <= CLASS_COMFORT;
      alpha_r     <= ALPHA_RESET;
      dark_r      <= DARK_RESET;
      bright_r    <= BRIGHT_RESET;
      hyst_r      <= HYST_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      smooth_r    <= smooth_nxt;
      class_r     <= class_nxt;
      alpha_r     <= alpha_nxt;
      dark_r      <= dark_nxt;
      bright_r    <= bright_nxt;
      hyst_r      <= hyst_nxt;
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) s1_data_r  <= in_data;
    if (s1_fire) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled without a request in flight");

  a_finish_comfort: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (cmd == CMD_CAL_FINISH) |=> out_data_r.light_class == CLASS_COMFORT)
    else $error("calibration finish did not report comfort");

  a_start_level: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (cmd == CMD_START) |=>
      out_data_r.smoothed_level == $past(s1_data_r.sample))
    else $error("start did not load the sample as level");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.light_class != 2'd3)
    else $error("invalid class code on result");

endmodule

### hdl/llc_ema.sv
// ----------------------------------------------------------------------------
// llc_ema: exponential moving average update
// new = old + floor(alpha * (sample - old) / 256), level in fixed point.
// ----------------------------------------------------------------------------
module llc_ema #(
  parameter int FRACTION_BITS = llc_pkg::FRACTION_BITS_DEF
) (
  input  logic [llc_pkg::SAMPLE_BITS+FRACTION_BITS-1:0] old_level,
  input  logic [llc_pkg::SAMPLE_BITS-1:0]               sample,
  input  logic [llc_pkg::ALPHA_BITS-1:0]                alpha,
  output logic [llc_pkg::SAMPLE_BITS+FRACTION_BITS-1:0] new_level
);
  import llc_pkg::*;

  localparam int SW = SAMPLE_BITS + FRACTION_BITS;

  logic [ALPHA_BITS-1:0]        alpha_c;
  logic signed [SW:0]           diff;
  logic signed [SW+ALPHA_BITS:0] prod;
  logic signed [SW+ALPHA_BITS:0] step;

  // Alpha above one acts as one.
  assign alpha_c = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign diff    = $signed({1'b0, sample, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, old_level});
  assign prod    = diff * $signed({1'b0, alpha_c});
  // Arithmetic shift floors toward minus infinity, matching the blended form.
  assign step    = prod >>> ALPHA_SHIFT;
  assign new_level = old_level + step[SW-1:0];

endmodule

### hdl/llc_calib.sv
// ----------------------------------------------------------------------------
// llc_calib: calibration range tracker
// Holds the running minimum and maximum and derives thresholds and
// hysteresis from their span.
// ----------------------------------------------------------------------------
module llc_calib (
  input  logic                            clk,
  input  logic                            rst_n,
  input  llc_pkg::cal_ctl_t               ctl,
  input  logic [llc_pkg::SAMPLE_BITS-1:0] sample,
  output llc_pkg::thr_t                   thr
);
  import llc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int DW   = SB + 3;
  localparam int PW10 = DW + 16;
  localparam int PW25 = SB + 13;
  localparam logic [15:0] RECIP10   = 16'd52429;
  localparam logic [12:0] RECIP25   = 13'd5243;
  localparam logic [SB-1:0] SPAN_MIN = SB'(10);
  localparam logic [SB-1:0] HYST_MIN = SB'(5);

  logic [SB-1:0]       min_r, min_nxt;
  logic [SB-1:0]       max_r, max_nxt;
  logic signed [SB:0]  span_raw;
  logic [SB-1:0]       span;
  logic [DW-1:0]       span3, span7;
  logic [PW10-1:0]     prod3, prod7;
  logic [PW25-1:0]     prod25;
  logic [SB:0]         bright_sum, dark_sum;
  logic [SB-1:0]       hyst_q;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.finish) begin
      min_nxt = SAMPLE_MAX;
      max_nxt = '0;
    end else if (ctl.take_sample) begin
      if (sample < min_r) min_nxt = sample;
      if (sample > max_r) max_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= SAMPLE_MAX;
      max_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // Span below the minimum (or negative with no samples) counts as the minimum.
  assign span_raw = $signed({1'b0, max_r}) - $signed({1'b0, min_r});
  assign span     = (span_raw < $signed({1'b0, SPAN_MIN})) ? SPAN_MIN : span_raw[SB-1:0];

  assign span3 = DW'(span) * DW'(3);
  assign span7 = DW'(span) * DW'(7);

  // Divide by 10 and 25 through scaled reciprocals, exact over this range.
  assign prod3  = PW10'(span3) * PW10'(RECIP10);
  assign prod7  = PW10'(span7) * PW10'(RECIP10);
  assign prod25 = PW25'(span) * PW25'(RECIP25);

  assign bright_sum = {1'b0, min_r} + {1'b0, prod3[PW10-1:19]};
  assign dark_sum   = {1'b0, min_r} + {1'b0, prod7[PW10-1:19]};
  assign hyst_q     = SB'(prod25[PW25-1:17]);

  assign thr.bright = bright_sum[SB] ? SAMPLE_MAX : bright_sum[SB-1:0];
  assign thr.dark   = dark_sum[SB]   ? SAMPLE_MAX : dark_sum[SB-1:0];
  assign thr.hyst   = (hyst_q < HYST_MIN) ? HYST_MIN : hyst_q;

  a_thr_order: assert property (@(posedge clk) disable iff (!rst_n)
    thr.bright <= thr.dark)
    else $error("calibrated bright threshold above dark threshold");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> (min_r == SAMPLE_MAX) && (max_r == '0))
    else $error("calibration finish did not clear the range");

endmodule
